>>> src/i2cmwe_pkg.sv
// Shared types and constants of the write-only I2C master engine.
package i2cmwe_pkg;

   // Bus sequencer phases; both idle phases come first.
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_IDLE_HELD = 4'd1,
      PH_WAIT      = 4'd2,
      PH_SETUP     = 4'd3,
      PH_HOLD      = 4'd4,
      PH_DLOW      = 4'd5,
      PH_DRISE     = 4'd6,
      PH_DHIGH     = 4'd7,
      PH_DTAIL     = 4'd8,
      PH_ALOW      = 4'd9,
      PH_ARISE     = 4'd10,
      PH_AHIGH     = 4'd11,
      PH_ATAIL     = 4'd12,
      PH_SRISE     = 4'd13,
      PH_SHIGH     = 4'd14,
      PH_STAIL     = 4'd15
   } phase_type;

   // Positions of the sticky error bits.
   localparam int ERR_NACK_BIT  = 0;
   localparam int ERR_STOP_BIT  = 1;
   localparam int ERR_START_BIT = 2;
   localparam int ERR_COLL_BIT  = 3;
   localparam int ERR_WIDTH     = 4;

   // Acknowledge sampling and shift register presets.
   localparam logic [7:0] NACK_MASK     = 8'h01;
   localparam logic [7:0] SHIFT_PRESET  = 8'hFF;
   localparam logic [3:0] ACK_BIT_START = 4'hE;

   // Configuration register indexes.
   localparam logic CSR_LOW_TICKS  = 1'b0;
   localparam logic CSR_HIGH_TICKS = 1'b1;

   // One timing tick of input.
   typedef struct packed {
      logic       go;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       scl_in;
      logic       sda_in;
      logic       clear_errors;
   } req_item_type;

   // One result of a tick.
   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       byte_taken;
      logic       busy_res;
      logic       done_res;
      logic       err_nack;
      logic       err_missing_stop;
      logic       err_unexpected_start;
      logic       err_collision;
   } rsp_item_type;

   // Bit timing registers.
   typedef struct packed {
      logic [7:0] low_ticks;
      logic [7:0] high_ticks;
   } timing_type;

endpackage

>>> src/i2cmwe_core.sv
// Bus sequencer state and the per-tick update of the I2C write engine.
module i2cmwe_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  i2cmwe_pkg::req_item_type item,
   input  i2cmwe_pkg::timing_type timing,
   output i2cmwe_pkg::rsp_item_type result
);

   i2cmwe_pkg::phase_type phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic       last_ff, last_in;
   logic [i2cmwe_pkg::ERR_WIDTH-1:0] err_ff, err_in;
   logic       prev_scl_ff, prev_scl_in;
   logic       prev_sda_ff, prev_sda_in;
   logic       stop_seen_ff, stop_seen_in;
   logic       start_seen_ff, start_seen_in;

   logic [7:0] low_eff, high_eff;
   logic       delay_done;
   logic       idle_now;
   logic       ack_phase;
   logic [3:0] bit_next;
   logic       taken, done;
   logic       scl_low, sda_low;

   // A zero delay register acts as one tick.
   assign low_eff  = (timing.low_ticks == 8'd0) ? 8'd1 : timing.low_ticks;
   assign high_eff = (timing.high_ticks == 8'd0) ? 8'd1 : timing.high_ticks;

   assign delay_done = (delay_ff <= 8'd1);
   assign idle_now   = (phase_ff == i2cmwe_pkg::PH_IDLE) ||
                       (phase_ff == i2cmwe_pkg::PH_IDLE_HELD);
   assign ack_phase  = (phase_ff == i2cmwe_pkg::PH_ALOW)  ||
                       (phase_ff == i2cmwe_pkg::PH_ARISE) ||
                       (phase_ff == i2cmwe_pkg::PH_AHIGH) ||
                       (phase_ff == i2cmwe_pkg::PH_ATAIL);
   assign bit_next   = bit_count_ff + 4'd1;

   // Next state of the sequencer for one tick.
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      last_in       = last_ff;
      err_in        = item.clear_errors ? '0 : err_ff;
      stop_seen_in  = stop_seen_ff |
                      (prev_scl_ff & item.scl_in & ~prev_sda_ff & item.sda_in);
      start_seen_in = start_seen_ff | (idle_now & prev_scl_ff & item.scl_in &
                                       prev_sda_ff & ~item.sda_in);
      prev_scl_in   = item.scl_in;
      prev_sda_in   = item.sda_in;
      taken         = 1'b0;
      done          = 1'b0;

      unique case (phase_ff)
         i2cmwe_pkg::PH_IDLE, i2cmwe_pkg::PH_IDLE_HELD: begin
            if (item.go) begin
               if (start_seen_in) err_in[i2cmwe_pkg::ERR_START_BIT] = 1'b1;
               if (!item.sda_in)  err_in[i2cmwe_pkg::ERR_COLL_BIT]  = 1'b1;
               start_seen_in = 1'b0;
               if (err_in != '0) done = 1'b1;
               else phase_in = i2cmwe_pkg::PH_WAIT;
            end
         end
         i2cmwe_pkg::PH_WAIT: begin
            if (item.scl_in) begin
               phase_in = i2cmwe_pkg::PH_SETUP;
               delay_in = high_eff;
            end
         end
         i2cmwe_pkg::PH_SETUP: begin
            if (delay_done) begin
               phase_in = i2cmwe_pkg::PH_HOLD;
               delay_in = high_eff;
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_HOLD: begin
            if (delay_done) begin
               taken = 1'b1;
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_DLOW, i2cmwe_pkg::PH_ALOW: begin
            if (delay_done) begin
               bit_count_in = bit_next;
               phase_in = ack_phase ? i2cmwe_pkg::PH_ARISE : i2cmwe_pkg::PH_DRISE;
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_DRISE, i2cmwe_pkg::PH_ARISE: begin
            if (item.scl_in) begin
               phase_in = ack_phase ? i2cmwe_pkg::PH_AHIGH : i2cmwe_pkg::PH_DHIGH;
               delay_in = high_eff;
            end
         end
         i2cmwe_pkg::PH_DHIGH, i2cmwe_pkg::PH_AHIGH: begin
            if (delay_done) begin
               shift_in     = {shift_ff[6:0], item.sda_in};
               bit_count_in = bit_next;
               delay_in     = low_eff;
               if (bit_next == 4'd0) begin
                  if (!ack_phase) shift_in = i2cmwe_pkg::SHIFT_PRESET;
                  phase_in = ack_phase ? i2cmwe_pkg::PH_ATAIL : i2cmwe_pkg::PH_DTAIL;
               end else begin
                  phase_in = ack_phase ? i2cmwe_pkg::PH_ALOW : i2cmwe_pkg::PH_DLOW;
               end
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_DTAIL: begin
            if (delay_done) begin
               shift_in     = i2cmwe_pkg::SHIFT_PRESET;
               bit_count_in = i2cmwe_pkg::ACK_BIT_START;
               phase_in     = i2cmwe_pkg::PH_ALOW;
               delay_in     = low_eff;
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_ATAIL: begin
            if (delay_done) begin
               shift_in = i2cmwe_pkg::SHIFT_PRESET;
               if ((shift_ff & i2cmwe_pkg::NACK_MASK) != 8'd0) begin
                  // Slave refused the byte: stop here with SCL still held.
                  err_in[i2cmwe_pkg::ERR_NACK_BIT] = 1'b1;
                  done     = 1'b1;
                  phase_in = i2cmwe_pkg::PH_IDLE_HELD;
               end else if (last_ff) begin
                  phase_in = i2cmwe_pkg::PH_SRISE;
               end else begin
                  taken = 1'b1;
               end
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_SRISE: begin
            if (item.scl_in) begin
               phase_in = i2cmwe_pkg::PH_SHIGH;
               delay_in = high_eff;
            end
         end
         i2cmwe_pkg::PH_SHIGH: begin
            if (delay_done) begin
               phase_in = i2cmwe_pkg::PH_STAIL;
               delay_in = low_eff;
            end else delay_in = delay_ff - 8'd1;
         end
         i2cmwe_pkg::PH_STAIL: begin
            if (delay_done) begin
               if (!stop_seen_in) err_in[i2cmwe_pkg::ERR_STOP_BIT] = 1'b1;
               done     = 1'b1;
               phase_in = i2cmwe_pkg::PH_IDLE;
            end else delay_in = delay_ff - 8'd1;
         end
         default: phase_in = i2cmwe_pkg::PH_IDLE;
      endcase

      // Latch the next byte and start its first data bit.
      if (taken) begin
         shift_in     = item.tx_byte;
         last_in      = item.tx_last;
         bit_count_in = 4'd0;
         stop_seen_in = 1'b0;
         phase_in     = i2cmwe_pkg::PH_DLOW;
         delay_in     = low_eff;
      end
   end

   // Line drive decoded from the phase after the update.
   always_comb begin
      scl_low = (phase_in == i2cmwe_pkg::PH_IDLE_HELD) ||
                (phase_in == i2cmwe_pkg::PH_DLOW)  ||
                (phase_in == i2cmwe_pkg::PH_DTAIL) ||
                (phase_in == i2cmwe_pkg::PH_ALOW)  ||
                (phase_in == i2cmwe_pkg::PH_ATAIL);
      sda_low = (phase_in == i2cmwe_pkg::PH_HOLD)  ||
                (phase_in == i2cmwe_pkg::PH_SRISE) ||
                (phase_in == i2cmwe_pkg::PH_SHIGH);
      if ((phase_in == i2cmwe_pkg::PH_DLOW) || (phase_in == i2cmwe_pkg::PH_DRISE) ||
          (phase_in == i2cmwe_pkg::PH_DHIGH)) begin
         sda_low = ~shift_in[7];
      end
   end

   always_comb begin
      result.scl_drive_low        = scl_low;
      result.sda_drive_low        = sda_low;
      result.byte_taken           = taken;
      result.busy_res             = (phase_in != i2cmwe_pkg::PH_IDLE) &&
                                    (phase_in != i2cmwe_pkg::PH_IDLE_HELD);
      result.done_res             = done;
      result.err_nack             = err_in[i2cmwe_pkg::ERR_NACK_BIT];
      result.err_missing_stop     = err_in[i2cmwe_pkg::ERR_STOP_BIT];
      result.err_unexpected_start = err_in[i2cmwe_pkg::ERR_START_BIT];
      result.err_collision        = err_in[i2cmwe_pkg::ERR_COLL_BIT];
   end

   // Sequencer state advances once per processed tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmwe_pkg::PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= i2cmwe_pkg::SHIFT_PRESET;
         delay_ff      <= 8'd0;
         last_ff       <= 1'b0;
         err_ff        <= '0;
         prev_scl_ff   <= 1'b1;
         prev_sda_ff   <= 1'b1;
         stop_seen_ff  <= 1'b0;
         start_seen_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         delay_ff      <= delay_in;
         last_ff       <= last_in;
         err_ff        <= err_in;
         prev_scl_ff   <= prev_scl_in;
         prev_sda_ff   <= prev_sda_in;
         stop_seen_ff  <= stop_seen_in;
         start_seen_ff <= start_seen_in;
      end
   end

endmodule

>>> src/i2c_master_write_engine.sv
// Top level of the write-only I2C master engine: channels, timing registers, staging.
//
// Use: every input transfer on req_ is one timing tick carrying the go request,
// the next message byte with its last-byte mark (req_tlast), the sampled SCL and
// SDA levels and a clear-errors request. Each tick yields exactly one result on
// rsp_ with the open-drain drive levels, the byte-taken and done pulses, busy and
// the four sticky error bits. The timing registers low_ticks (index 0) and
// high_ticks (index 1) are written through csr_; the user must write them only
// while no transaction runs, as the block itself does not enforce it. Throughput is
// one tick per clock cycle while rsp_tready stays high: the whole update of the
// sequencer sits between the input register and the result register, and the
// result of a tick passes through both before it shows on rsp_tvalid/rsp_tdata.
// Reset (synchronous) empties both registers, idles the sequencer with both lines
// released, clears all errors and loads low_ticks = 13 and high_ticks = 6.
// When the receiver stalls, the result register holds its transfer and the input
// register still takes one more tick; req_tready then drops until rsp_tready
// returns, and no tick is lost or processed twice.
module i2c_master_write_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] go, [8:1] tx_byte, [9] scl_in, [10] sda_in, [11] clear_errors, [15:12] zero
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_drive_low, [1] sda_drive_low, [2] byte_taken, [3] busy_res,
   // [4] done_res, [5] err_nack, [6] err_missing_stop, [7] err_unexpected_start,
   // [8] err_collision, [15:9] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   i2cmwe_pkg::timing_type   timing_ff;
   i2cmwe_pkg::req_item_type req_ff, req_in;
   logic                     req_valid_ff;
   i2cmwe_pkg::rsp_item_type rsp_ff, step_result;
   logic                     rsp_valid_ff;
   logic                     advance;
   logic                     step_en;

   // Result register is free or being emptied this cycle.
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign step_en    = req_valid_ff & advance;
   assign req_tready = ~req_valid_ff | advance;

   // Unpack the input transfer.
   always_comb begin
      req_in.go           = req_tdata[0];
      req_in.tx_byte      = req_tdata[8:1];
      req_in.tx_last      = req_tlast;
      req_in.scl_in       = req_tdata[9];
      req_in.sda_in       = req_tdata[10];
      req_in.clear_errors = req_tdata[11];
   end

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.low_ticks  <= 8'd13;
         timing_ff.high_ticks <= 8'd6;
      end else if (csr_we) begin
         case (csr_index)
            i2cmwe_pkg::CSR_LOW_TICKS:  timing_ff.low_ticks  <= csr_wdata;
            i2cmwe_pkg::CSR_HIGH_TICKS: timing_ff.high_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) req_valid_ff <= 1'b0;
      else if (req_tready) req_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) req_ff <= req_in;
   end

   i2cmwe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (req_ff),
      .timing  (timing_ff),
      .result  (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= req_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (step_en) rsp_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.err_collision,
                        rsp_ff.err_unexpected_start,
                        rsp_ff.err_missing_stop,
                        rsp_ff.err_nack,
                        rsp_ff.done_res,
                        rsp_ff.busy_res,
                        rsp_ff.byte_taken,
                        rsp_ff.sda_drive_low,
                        rsp_ff.scl_drive_low};

endmodule

>>> src/i2cmwe_checker.sv
// Port-level checks of the I2C write engine and their binding to the top level.
module i2cmwe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result transfer keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A taken byte always belongs to a running transaction.
   a_taken_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[3])
      else $error("byte taken while not busy");

   // A transaction ends in an idle phase.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[3] && !rsp_tdata[2])
      else $error("done while still busy");

endmodule

bind i2c_master_write_engine i2cmwe_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb.sv
// Self-checking testbench for the write-only I2C master engine, with its own tick predictor.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 400000;

   // Predicts the result of every accepted tick and holds the results still to come.
   class i2c_write_predictor;
      logic [7:0]                       low_t = 8'd13;
      logic [7:0]                       high_t = 8'd6;
      i2cmwe_pkg::phase_type            phase = i2cmwe_pkg::PH_IDLE;
      logic [3:0]                       bit_cnt = '0;
      logic [7:0]                       shreg = i2cmwe_pkg::SHIFT_PRESET;
      logic [7:0]                       dly = '0;
      logic                             last_flag = 1'b0;
      logic [i2cmwe_pkg::ERR_WIDTH-1:0] errs = '0;
      logic                             prev_scl = 1'b1;
      logic                             prev_sda = 1'b1;
      logic                             stop_seen = 1'b0;
      logic                             idle_start = 1'b0;
      i2cmwe_pkg::rsp_item_type         expected_lines[$];
      i2cmwe_pkg::rsp_item_type         last_out = '0;
      int                               mismatches = 0;
      int                               ticks = 0;
      int                               bytes_sent = 0;
      int                               endings = 0;
      int                               nacks = 0;

      function void set_timing(logic [7:0] low_v, logic [7:0] high_v);
         low_t = low_v;
         high_t = high_v;
      endfunction

      // A delay register of zero counts as one tick.
      function void enter(i2cmwe_pkg::phase_type p, logic [7:0] t);
         phase = p;
         dly = (t == 8'd0) ? 8'd1 : t;
      endfunction

      function bit delay_over();
         if (dly <= 8'd1) return 1'b1;
         dly = dly - 8'd1;
         return 1'b0;
      endfunction

      function void load_byte(i2cmwe_pkg::req_item_type it);
         shreg = it.tx_byte;
         last_flag = it.tx_last;
         bit_cnt = '0;
         stop_seen = 1'b0;
         enter(i2cmwe_pkg::PH_DLOW, low_t);
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      // Advances the sequencer by one accepted tick and queues its result.
      function void note_tick(i2cmwe_pkg::req_item_type it);
         i2cmwe_pkg::rsp_item_type r;
         logic         taken;
         logic         done;
         logic         idle;
         logic         ack;
         logic         nack;
         taken = 1'b0;
         done = 1'b0;
         idle = (phase == i2cmwe_pkg::PH_IDLE || phase == i2cmwe_pkg::PH_IDLE_HELD);
         // Clear goes first, so an error raised in this tick stays set.
         if (it.clear_errors) errs = '0;
         if (prev_scl && it.scl_in && !prev_sda && it.sda_in) stop_seen = 1'b1;
         if (idle && prev_scl && it.scl_in && prev_sda && !it.sda_in) idle_start = 1'b1;
         ack = (phase >= i2cmwe_pkg::PH_ALOW && phase <= i2cmwe_pkg::PH_ATAIL);
         case (phase)
            i2cmwe_pkg::PH_IDLE, i2cmwe_pkg::PH_IDLE_HELD: begin
               if (it.go) begin
                  if (idle_start) errs[i2cmwe_pkg::ERR_START_BIT] = 1'b1;
                  if (!it.sda_in) errs[i2cmwe_pkg::ERR_COLL_BIT] = 1'b1;
                  idle_start = 1'b0;
                  if (errs != 0) done = 1'b1;
                  else phase = i2cmwe_pkg::PH_WAIT;
               end
            end
            i2cmwe_pkg::PH_WAIT: begin
               if (it.scl_in) enter(i2cmwe_pkg::PH_SETUP, high_t);
            end
            i2cmwe_pkg::PH_SETUP: begin
               if (delay_over()) enter(i2cmwe_pkg::PH_HOLD, high_t);
            end
            i2cmwe_pkg::PH_HOLD: begin
               if (delay_over()) begin
                  load_byte(it);
                  taken = 1'b1;
               end
            end
            i2cmwe_pkg::PH_DLOW, i2cmwe_pkg::PH_ALOW: begin
               if (delay_over()) begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (ack) phase = i2cmwe_pkg::PH_ARISE;
                  else phase = i2cmwe_pkg::PH_DRISE;
               end
            end
            i2cmwe_pkg::PH_DRISE, i2cmwe_pkg::PH_ARISE: begin
               if (it.scl_in) begin
                  if (ack) enter(i2cmwe_pkg::PH_AHIGH, high_t);
                  else enter(i2cmwe_pkg::PH_DHIGH, high_t);
               end
            end
            i2cmwe_pkg::PH_DHIGH, i2cmwe_pkg::PH_AHIGH: begin
               if (delay_over()) begin
                  shreg = {shreg[6:0], it.sda_in};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt == 4'd0) begin
                     if (ack) begin
                        enter(i2cmwe_pkg::PH_ATAIL, low_t);
                     end else begin
                        shreg = i2cmwe_pkg::SHIFT_PRESET;
                        enter(i2cmwe_pkg::PH_DTAIL, low_t);
                     end
                  end else if (ack) begin
                     enter(i2cmwe_pkg::PH_ALOW, low_t);
                  end else begin
                     enter(i2cmwe_pkg::PH_DLOW, low_t);
                  end
               end
            end
            i2cmwe_pkg::PH_DTAIL: begin
               if (delay_over()) begin
                  shreg = i2cmwe_pkg::SHIFT_PRESET;
                  bit_cnt = i2cmwe_pkg::ACK_BIT_START;
                  enter(i2cmwe_pkg::PH_ALOW, low_t);
               end
            end
            i2cmwe_pkg::PH_ATAIL: begin
               if (delay_over()) begin
                  nack = (shreg & i2cmwe_pkg::NACK_MASK) != 8'd0;
                  shreg = i2cmwe_pkg::SHIFT_PRESET;
                  if (nack) begin
                     errs[i2cmwe_pkg::ERR_NACK_BIT] = 1'b1;
                     done = 1'b1;
                     phase = i2cmwe_pkg::PH_IDLE_HELD;
                     nacks++;
                  end else if (last_flag) begin
                     phase = i2cmwe_pkg::PH_SRISE;
                  end else begin
                     load_byte(it);
                     taken = 1'b1;
                  end
               end
            end
            i2cmwe_pkg::PH_SRISE: begin
               if (it.scl_in) enter(i2cmwe_pkg::PH_SHIGH, high_t);
            end
            i2cmwe_pkg::PH_SHIGH: begin
               if (delay_over()) enter(i2cmwe_pkg::PH_STAIL, low_t);
            end
            default: begin
               if (delay_over()) begin
                  if (!stop_seen) errs[i2cmwe_pkg::ERR_STOP_BIT] = 1'b1;
                  done = 1'b1;
                  phase = i2cmwe_pkg::PH_IDLE;
               end
            end
         endcase
         prev_scl = it.scl_in;
         prev_sda = it.sda_in;

         // Drive levels and flags as seen after this tick's update.
         r.scl_drive_low = phase inside {i2cmwe_pkg::PH_IDLE_HELD, i2cmwe_pkg::PH_DLOW,
                                         i2cmwe_pkg::PH_DTAIL, i2cmwe_pkg::PH_ALOW,
                                         i2cmwe_pkg::PH_ATAIL};
         r.sda_drive_low = phase inside {i2cmwe_pkg::PH_HOLD, i2cmwe_pkg::PH_SRISE,
                                         i2cmwe_pkg::PH_SHIGH};
         if (phase inside {i2cmwe_pkg::PH_DLOW, i2cmwe_pkg::PH_DRISE, i2cmwe_pkg::PH_DHIGH})
            r.sda_drive_low = !shreg[7];
         r.byte_taken = taken;
         r.busy_res = !(phase inside {i2cmwe_pkg::PH_IDLE, i2cmwe_pkg::PH_IDLE_HELD});
         r.done_res = done;
         r.err_nack = errs[i2cmwe_pkg::ERR_NACK_BIT];
         r.err_missing_stop = errs[i2cmwe_pkg::ERR_STOP_BIT];
         r.err_unexpected_start = errs[i2cmwe_pkg::ERR_START_BIT];
         r.err_collision = errs[i2cmwe_pkg::ERR_COLL_BIT];
         expected_lines.push_back(r);
         last_out = r;
         ticks++;
         if (taken) bytes_sent++;
         if (done) endings++;
      endfunction

      // Compares one result transfer with the oldest predicted result.
      function void check_result(logic [15:0] d);
         i2cmwe_pkg::rsp_item_type e;
         logic [15:0]  w;
         logic [15:0]  m;
         string        fname [10] = '{"scl_drive_low", "sda_drive_low", "byte_taken",
                                      "busy_res", "done_res", "err_nack",
                                      "err_missing_stop", "err_unexpected_start",
                                      "err_collision", "padding"};
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result %h arrived with none expected", d);
            return;
         end
         e = expected_lines.pop_front();
         w = {7'd0, e.err_collision, e.err_unexpected_start, e.err_missing_stop,
              e.err_nack, e.done_res, e.busy_res, e.byte_taken, e.sda_drive_low,
              e.scl_drive_low};
         for (int i = 0; i < 10; i++) begin
            m = (i == 9) ? 16'hFE00 : (16'h0001 << i);
            if ((d & m) !== (w & m)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch in %s at %0t: expected %h, actual %h",
                           fname[i], $realtime, w, d);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;

   i2c_master_write_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   i2c_write_predictor pred = new();
   int  snd_pct = 0;
   int  rcv_pct = 0;
   int  cycle_count = 0;
   bit  slave_nack = 1'b0;
   bit  hold_stop = 1'b0;

   always #2 clock = ~clock;

   // Result side: check each transfer and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pred.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rcv_pct);
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("i2c_master_write_engine test failed");
         $finish;
      end
   end

   function automatic i2cmwe_pkg::req_item_type mk(logic go, logic [7:0] b, logic last,
                                                   logic scl, logic sda, logic clr);
      i2cmwe_pkg::req_item_type it;
      it.go = go;
      it.tx_byte = b;
      it.tx_last = last;
      it.scl_in = scl;
      it.sda_in = sda;
      it.clear_errors = clr;
      return it;
   endfunction

   // Builds the next tick from a simple bus: the lines follow the master's drive,
   // a slave answers the acknowledge bits and sometimes stretches the clock.
   function automatic i2cmwe_pkg::req_item_type next_tick(bit allow_go, bit allow_noise,
                                                          bit force_last);
      i2cmwe_pkg::req_item_type it;
      i2cmwe_pkg::rsp_item_type o;
      i2cmwe_pkg::phase_type    p;
      o = pred.last_out;
      p = pred.phase;
      if (o.byte_taken) begin
         slave_nack = ($urandom_range(11) == 0);
         hold_stop = ($urandom_range(5) == 0);
      end
      it.go = 1'($urandom_range(1));
      it.tx_byte = 8'($urandom_range(255));
      it.tx_last = force_last || ($urandom_range(2) == 0);
      it.clear_errors = ($urandom_range(49) == 0);
      it.scl_in = !o.scl_drive_low;
      it.sda_in = !o.sda_drive_low;
      case (p)
         i2cmwe_pkg::PH_IDLE, i2cmwe_pkg::PH_IDLE_HELD: begin
            if (pred.errs != 0 && $urandom_range(3) != 0) it.clear_errors = 1'b1;
            it.go = allow_go && ($urandom_range(5) == 0);
            // Occasional foreign start or collision on SDA.
            if ($urandom_range(24) == 0) it.sda_in = 1'b0;
            if (p == i2cmwe_pkg::PH_IDLE && $urandom_range(24) == 0) it.scl_in = 1'b0;
         end
         i2cmwe_pkg::PH_WAIT, i2cmwe_pkg::PH_DRISE, i2cmwe_pkg::PH_ARISE,
         i2cmwe_pkg::PH_SRISE: begin
            if ($urandom_range(2) == 0) it.scl_in = 1'b0;
         end
         default: ;
      endcase
      if (p >= i2cmwe_pkg::PH_ALOW && p <= i2cmwe_pkg::PH_AHIGH) it.sda_in = slave_nack;
      if (p == i2cmwe_pkg::PH_STAIL && hold_stop) it.sda_in = 1'b0;
      if (allow_noise && $urandom_range(19) == 0) begin
         it.go = 1'($urandom_range(1));
         it.scl_in = 1'($urandom_range(1));
         it.sda_in = 1'($urandom_range(1));
         it.clear_errors = 1'($urandom_range(1));
      end
      return it;
   endfunction

   // Offers one tick, idling first at random, and notes it once transferred.
   task automatic send_tick(i2cmwe_pkg::req_item_type it);
      while ($urandom_range(99) < snd_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, it.clear_errors, it.sda_in, it.scl_in, it.tx_byte, it.go};
      req_tlast <= it.tx_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred.note_tick(it);
   endtask

   // Runs the bus until the sequencer is back in an idle phase.
   task automatic finish_transfer();
      while (!(pred.phase == i2cmwe_pkg::PH_IDLE || pred.phase == i2cmwe_pkg::PH_IDLE_HELD))
         send_tick(next_tick(1'b0, 1'b0, 1'b1));
   endtask

   // Waits for every predicted result, then lets the pipeline run empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pred.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timing(logic [7:0] low_v, logic [7:0] high_v);
      csr_we <= 1'b1;
      csr_index <= i2cmwe_pkg::CSR_LOW_TICKS;
      csr_wdata <= low_v;
      @(posedge clock);
      csr_index <= i2cmwe_pkg::CSR_HIGH_TICKS;
      csr_wdata <= high_v;
      @(posedge clock);
      csr_we <= 1'b0;
      pred.set_timing(low_v, high_v);
   endtask

   task automatic run_random(int count, bit drain_mid);
      for (int i = 0; i < count; i++) begin
         // Hold off the sender until all results so far have come back.
         if (drain_mid && i == count / 2) begin
            req_tvalid <= 1'b0;
            while (pred.pending() != 0) @(posedge clock);
         end
         send_tick(next_tick(1'b1, 1'b1, 1'b0));
      end
      finish_transfer();
      settle();
   endtask

   initial begin
      i2cmwe_pkg::req_item_type directed [11];
      logic [7:0]   low_v [5] = '{8'd0, 8'd5, 8'd12, 8'd3, 8'd1};
      logic [7:0]   high_v [5] = '{8'd0, 8'd3, 8'd9, 8'd1, 8'd2};
      int           count_v [5] = '{240, 240, 70, 240, 240};
      int           mode_v [5] = '{0, 0, 1, 1, 2};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset timing.
      directed[0] = mk(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      directed[1] = mk(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
      // SDA falls with SCL high while idle: a foreign start.
      directed[2] = mk(1'b0, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b0);
      // SDA rises with SCL high: a stop condition.
      directed[3] = mk(1'b0, 8'h5A, 1'b1, 1'b1, 1'b1, 1'b0);
      // Go after the foreign start is refused.
      directed[4] = mk(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      // Clear and a new collision in the same tick: the collision stays.
      directed[5] = mk(1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
      directed[6] = mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      directed[7] = mk(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      // Accepted go while another device holds SCL low.
      directed[8] = mk(1'b1, 8'h3C, 1'b0, 1'b0, 1'b1, 1'b0);
      // Go while busy is ignored.
      directed[9] = mk(1'b1, 8'hC3, 1'b0, 1'b0, 1'b1, 1'b0);
      directed[10] = mk(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
      foreach (directed[i]) send_tick(directed[i]);
      finish_transfer();
      settle();

      // Random phases over several timings, zero delay registers among them.
      for (int p = 0; p < 5; p++) begin
         set_timing(low_v[p], high_v[p]);
         snd_pct = (mode_v[p] == 0) ? 28 : (mode_v[p] == 1) ? 47 : 0;
         rcv_pct = (mode_v[p] == 0) ? 47 : (mode_v[p] == 1) ? 28 : 0;
         run_random(count_v[p], p == 1);
      end

      $display("Run covered %0d ticks, %0d bytes sent, %0d transactions ended or refused,",
               pred.ticks, pred.bytes_sent, pred.endings);
      $display("%0d of them on a NACK, over six timing settings; %0d mismatches.",
               pred.nacks, pred.mismatches);
      if (pred.mismatches == 0 && pred.pending() == 0) begin
         $display("i2c_master_write_engine test passed");
      end else begin
         $display("i2c_master_write_engine test failed");
      end
      $finish;
   end

endmodule
